/* src/cfr_pkg.sv */
// Shared types and codes for the checked frame receiver.
// No dependencies; imported by every module of the block.
`default_nettype none

package cfr_pkg;

	typedef enum logic [1:0] {
		S_IDLE    = 2'd0,
		S_COLLECT = 2'd1,
		S_DISCARD = 2'd2,
		S_REPLAY  = 2'd3
	} cfr_state_t;

	typedef enum logic [2:0] {
		STAT_OK       = 3'd0,
		STAT_NO_START = 3'd1,
		STAT_COUNT    = 3'd2,
		STAT_CHECKSUM = 3'd3,
		STAT_OVERFLOW = 3'd4
	} cfr_status_t;

	localparam logic CFG_START_CODE = 1'b0;
	localparam logic CFG_END_CODE   = 1'b1;

	localparam logic [7:0] START_CODE_RST = 8'hFF;
	localparam logic [7:0] END_CODE_RST   = 8'hFE;

	// one result item as it leaves the controller
	typedef struct packed {
		logic        is_error;
		cfr_status_t status;
		logic [7:0]  frame_byte;
		logic [3:0]  position;
		logic        last;
	} cfr_result_t;

endpackage

`default_nettype wire

/* src/cfr_frame_store.sv */
// Frame byte store: one write port, one read port with registered data.
// Imports cfr_pkg; no other dependencies.
`default_nettype none

module cfr_frame_store
	import cfr_pkg::*;
#(
	parameter int MAX_FRAME = 16,
	localparam int AW = $clog2(MAX_FRAME)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata
);

	logic [7:0] mem [MAX_FRAME];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* src/cfr_out_stage.sv */
// Output register for result items, parting controller from the master side.
// Depends on cfr_pkg for cfr_result_t.
`default_nettype none

module cfr_out_stage
	import cfr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire cfr_result_t push_res,
	output logic             free,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output cfr_result_t      res
);

	logic        valid_q;
	cfr_result_t res_q;

	assign free     = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign res      = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			res_q <= push_res;
		end
	end

endmodule

`default_nettype wire

/* src/cfr_ctrl.sv */
// Frame controller: phase machine, length and checksum checks, replay sequencer.
// Depends on cfr_pkg; drives the store ports and feeds cfr_out_stage.
`default_nettype none

module cfr_ctrl
	import cfr_pkg::*;
#(
	parameter int MAX_FRAME = 16,
	localparam int AW = $clog2(MAX_FRAME),
	localparam int CW = $clog2(MAX_FRAME + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic          cfg_index,
	input  wire logic [7:0]    cfg_wdata,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [7:0]    rx_byte,
	output logic               mem_we,
	output logic      [AW-1:0] mem_waddr,
	output logic               mem_re,
	output logic      [AW-1:0] mem_raddr,
	input  wire logic [7:0]    mem_rdata,
	input  wire logic          out_free,
	output logic               push,
	output cfr_result_t        push_res
);

	localparam int WW = (CW > 8) ? CW : 8;

	cfr_state_t  state_q, state_d;
	logic [7:0]  start_q, end_q;
	logic [CW-1:0] total_q, size_q, rd_idx_q;
	logic [7:0]  sum_q, prev_q, byte1_q;
	logic        ovf_q;
	logic        rd_pend_s1, rd_last_s1;
	logic [3:0]  rd_pos_s1;

	logic        acc, room, move, issue, push_err, go_replay;
	logic        count_bad, sum_bad;
	logic [7:0]  byte1_val;
	cfr_status_t err_code;

	assign acc  = s_tvalid && s_tready;
	assign room = total_q < CW'(MAX_FRAME);
	assign move = rd_pend_s1 && out_free;
	// reads only run in replay, writes only on accepted bytes: never both
	assign issue = (state_q == S_REPLAY) && (rd_idx_q != size_q) && (!rd_pend_s1 || move);

	assign s_tready  = (state_q != S_REPLAY) && out_free;
	// the start code of a new frame always lands in entry zero
	assign mem_waddr = (state_q == S_COLLECT) ? total_q[AW-1:0] : '0;
	assign mem_re    = issue;
	assign mem_raddr = rd_idx_q[AW-1:0];

	// byte two is the current byte when the frame is only two long
	assign byte1_val = (total_q == CW'(1)) ? rx_byte : byte1_q;
	assign count_bad = WW'(byte1_val) != WW'(CW'(total_q - CW'(1)));
	assign sum_bad   = prev_q != 8'(sum_q - prev_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= START_CODE_RST;
			end_q   <= END_CODE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_START_CODE: start_q <= cfg_wdata;
				CFG_END_CODE:   end_q   <= cfg_wdata;
				default:        ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		push_err  = 1'b0;
		go_replay = 1'b0;
		err_code  = STAT_OK;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					if (rx_byte == start_q) begin
						state_d = S_COLLECT;
						mem_we  = 1'b1;
					end else begin
						state_d = S_DISCARD;
					end
				end
			end
			S_COLLECT: begin
				if (acc) begin
					mem_we = room;
					if (rx_byte == end_q) begin
						state_d  = S_IDLE;
						push_err = 1'b1;
						if (ovf_q || !room) begin
							err_code = STAT_OVERFLOW;
						end else if (count_bad) begin
							err_code = STAT_COUNT;
						end else if (sum_bad) begin
							err_code = STAT_CHECKSUM;
						end else begin
							push_err  = 1'b0;
							go_replay = 1'b1;
							state_d   = S_REPLAY;
						end
					end
				end
			end
			S_DISCARD: begin
				if (acc && rx_byte == end_q) begin
					state_d  = S_IDLE;
					push_err = 1'b1;
					err_code = STAT_NO_START;
				end
			end
			S_REPLAY: begin
				if (move && rd_last_s1) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign push = push_err || move;

	always_comb begin
		if (move) begin
			push_res = '{is_error: 1'b0, status: STAT_OK, frame_byte: mem_rdata,
				position: rd_pos_s1, last: rd_last_s1};
		end else begin
			push_res = '{is_error: 1'b1, status: err_code, frame_byte: 8'd0,
				position: 4'd0, last: 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q    <= '0;
			sum_q      <= '0;
			ovf_q      <= 1'b0;
			size_q     <= '0;
			rd_idx_q   <= '0;
			rd_pend_s1 <= 1'b0;
		end else begin
			if (acc) begin
				case (state_q)
					S_IDLE: begin
						total_q <= (rx_byte == start_q) ? CW'(1) : '0;
						sum_q   <= rx_byte;
						ovf_q   <= 1'b0;
					end
					S_COLLECT: begin
						if (room) begin
							total_q <= total_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						sum_q <= sum_q + rx_byte;
					end
					default: ;
				endcase
			end
			if (go_replay) begin
				size_q   <= total_q + CW'(1);
				rd_idx_q <= '0;
			end
			if (issue) begin
				rd_idx_q   <= rd_idx_q + CW'(1);
				rd_pend_s1 <= 1'b1;
			end else if (move) begin
				rd_pend_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			prev_q <= rx_byte;
			if (state_q == S_COLLECT && total_q == CW'(1)) begin
				byte1_q <= rx_byte;
			end
		end
		if (issue) begin
			rd_pos_s1  <= 4'(rd_idx_q);
			rd_last_s1 <= (rd_idx_q + CW'(1)) == size_q;
		end
	end

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free)
		else $error("result pushed into a busy output register");

	a_pend_in_replay: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> state_q == S_REPLAY)
		else $error("read data pending outside replay");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> rd_idx_q < size_q && size_q <= CW'(MAX_FRAME))
		else $error("replay read beyond frame");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !mem_re && !rd_pend_s1)
		else $error("store write overlaps replay");

	a_collect_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_COLLECT |-> total_q != '0)
		else $error("collecting with empty frame count");

endmodule

`default_nettype wire

/* src/checked_frame_receiver.sv */
// Top level of the checked frame receiver: start/end delimited frames with an
// additive checksum. Depends on cfr_pkg, cfr_frame_store, cfr_ctrl, cfr_out_stage.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-------------------------------------
//  s_*      | in        | s_tvalid / s_tready  | s_tdata[7:0] rx_byte
//  m_*      | out       | m_tvalid / m_tready  | m_tdata byte+position, m_tuser flags,
//           |           |                      | m_tlast last
//  cfg_*    | in        | cfg_we (no wait)     | cfg_index, cfg_wdata
//
// Replay: the end byte of a good frame starts a replay from the store, one byte a
// cycle through its single read port while the output register is free, so
// s_tready stays low for the whole replay, including any m_tready stall.
// Errors come out as one item straight after the end byte.
// Reset: asynchronous, clears the phase, counters and output valid; the frame
// store is not cleared (only entries of the current frame are ever read).
// Stalls: s_tready follows the output register, so a held result item stops input.
`default_nettype none

module checked_frame_receiver
	import cfr_pkg::*;
#(
	parameter int MAX_FRAME = 16,
	localparam int AW = $clog2(MAX_FRAME)
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write port
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [7:0]  cfg_wdata,
	// received bytes
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	// result items
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [15:0] m_tdata,   // [7:0] frame_byte, [11:8] position, rest zero
	output logic      [3:0]  m_tuser,   // [0] is_error, [3:1] status
	output logic             m_tlast    // last
);

	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [7:0]    mem_rdata;
	logic          out_free, push;
	cfr_result_t   push_res, res;

	cfr_frame_store #(.MAX_FRAME(MAX_FRAME)) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (s_tdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	cfr_ctrl #(.MAX_FRAME(MAX_FRAME)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.rx_byte   (s_tdata),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.out_free  (out_free),
		.push      (push),
		.push_res  (push_res)
	);

	// output register: results wait here for m_tready
	cfr_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_res (push_res),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.res      (res)
	);

	assign m_tdata = {4'd0, res.position, res.frame_byte};
	assign m_tuser = {res.status, res.is_error};
	assign m_tlast = res.last;

endmodule

`default_nettype wire
